@@ rtl/core/laq_pkg.sv @@
// Shared types and constants for the line assembly ring queue.
package laq_pkg;

    localparam int LEN_W   = 6;
    localparam int RTC_LEN = 6;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam logic [2:0] EV_STORED      = 3'd0;
    localparam logic [2:0] EV_CLOSED      = 3'd1;
    localparam logic [2:0] EV_OVERFLOW    = 3'd2;
    localparam logic [2:0] EV_FULL        = 3'd3;
    localparam logic [2:0] EV_BYTE        = 3'd4;
    localparam logic [2:0] EV_EMPTY_LINE  = 3'd5;
    localparam logic [2:0] EV_QUEUE_EMPTY = 3'd6;

    localparam logic OP_RX      = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
        logic       is_term;
    } item_t;

    // "setrtc" prefix character at position i
    function automatic logic [7:0] rtc_char(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0:    c = 8'h73;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h72;
            3'd4:    c = 8'h74;
            3'd5:    c = 8'h63;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/laq_front.sv @@
// Input side: accepts beats, marks line terminators, buffers them in a two-entry queue.
module laq_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_opcode,
    input  logic [7:0]     s_rx_byte,
    output laq_pkg::item_t item,
    output logic           item_valid,
    input  logic           item_ready
);
    import laq_pkg::*;

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    item_t      in_item;

    assign s_ready    = (count_reg != 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign push       = s_valid && s_ready;
    assign pop        = item_valid && item_ready;

    always_comb begin
        in_item.opcode  = s_opcode;
        in_item.rx_byte = s_rx_byte;
        in_item.is_term = (s_rx_byte == CHAR_LF) || (s_rx_byte == CHAR_CR);
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ rtl/core/laq_back.sv @@
// Execution side: line assembly into the slot ring, dequeue streaming, result register.
module laq_back #(
    parameter int QUEUE_SLOTS = 16,
    parameter int LINE_BYTES  = 40
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  laq_pkg::item_t             item,
    input  logic                       item_valid,
    output logic                       item_ready,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_event_res,
    output logic [7:0]                 m_data_byte,
    output logic [laq_pkg::LEN_W-1:0]  m_line_length,
    output logic                       m_rtc_command,
    output logic                       m_last
);
    import laq_pkg::*;

    localparam int SLOT_W = $clog2(QUEUE_SLOTS);
    localparam int FILL_W = $clog2(LINE_BYTES);
    localparam int DEPTH  = QUEUE_SLOTS * LINE_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);
    localparam logic [FILL_W-1:0] MAX_FILL  = FILL_W'(LINE_BYTES - 1);
    localparam logic [FILL_W-1:0] TAG_FILL  = FILL_W'(RTC_LEN);
    localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((QUEUE_SLOTS - 1) * LINE_BYTES);
    localparam logic [ADDR_W-1:0] STRIDE    = ADDR_W'(LINE_BYTES);

    typedef enum logic [1:0] {S_IDLE, S_META, S_STREAM} state_t;

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  wslot_reg, wslot_next, rslot_reg, rslot_next, wslot_inc;
    logic [ADDR_W-1:0]  wbase_reg, wbase_next, rbase_reg, rbase_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next, cnt_reg, cnt_next, len_reg, len_next;
    logic               prefix_reg, prefix_next, rtc_reg, rtc_next;
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_ev_reg, out_ev_next;
    logic [7:0]         out_data_reg, out_data_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;
    logic               out_rtc_reg, out_rtc_next, out_last_reg, out_last_next;

    logic [7:0]         line_mem [DEPTH];
    logic [FILL_W:0]    meta_mem [QUEUE_SLOTS];
    logic [7:0]         byte_rd_reg;
    logic [FILL_W:0]    meta_rd_reg;

    logic               byte_we, byte_re, meta_we, meta_re;
    logic [ADDR_W-1:0]  byte_waddr;
    logic [FILL_W:0]    meta_wdata;
    logic               out_free, full, ring_empty;
    logic [FILL_W-1:0]  meta_len;

    assign out_free   = !out_valid_reg || m_ready;
    assign wslot_inc  = (wslot_reg == LAST_SLOT) ? '0 : wslot_reg + 1'b1;
    assign full       = (wslot_inc == rslot_reg);
    assign ring_empty = (rslot_reg == wslot_reg);
    assign byte_waddr = wbase_reg + ADDR_W'(fill_reg);
    assign meta_len   = meta_rd_reg[FILL_W-1:0];
    assign meta_wdata = {prefix_reg && (fill_reg >= TAG_FILL), fill_reg};

    always_comb begin
        state_next     = state_reg;
        wslot_next     = wslot_reg;
        rslot_next     = rslot_reg;
        wbase_next     = wbase_reg;
        rbase_next     = rbase_reg;
        addr_next      = addr_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        prefix_next    = prefix_reg;
        rtc_next       = rtc_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_ev_next    = out_ev_reg;
        out_data_next  = out_data_reg;
        out_len_next   = out_len_reg;
        out_rtc_next   = out_rtc_reg;
        out_last_next  = out_last_reg;
        item_ready     = 1'b0;
        byte_we        = 1'b0;
        byte_re        = 1'b0;
        meta_we        = 1'b0;
        meta_re        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (item_valid && item.opcode == OP_RX && out_free) begin
                    item_ready     = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = 8'h00;
                    out_len_next   = '0;
                    out_rtc_next   = 1'b0;
                    out_last_next  = 1'b1;
                    if (full) begin
                        out_ev_next = EV_FULL;
                    end else if (item.is_term) begin
                        meta_we      = 1'b1;
                        out_ev_next  = EV_CLOSED;
                        out_len_next = LEN_W'(fill_reg);
                        fill_next    = '0;
                        wslot_next   = wslot_inc;
                        wbase_next   = (wbase_reg == LAST_BASE) ? '0 : wbase_reg + STRIDE;
                    end else if (fill_reg >= MAX_FILL) begin
                        out_ev_next = EV_OVERFLOW;
                        fill_next   = '0;
                    end else begin
                        byte_we     = 1'b1;
                        out_ev_next = EV_STORED;
                        fill_next   = fill_reg + 1'b1;
                        if (fill_reg < TAG_FILL) begin
                            prefix_next = (fill_reg == '0 || prefix_reg) &&
                                          (item.rx_byte == rtc_char(fill_reg[2:0]));
                        end
                    end
                end else if (item_valid && item.opcode == OP_DEQUEUE) begin
                    if (ring_empty) begin
                        if (out_free) begin
                            item_ready     = 1'b1;
                            out_valid_next = 1'b1;
                            out_ev_next    = EV_QUEUE_EMPTY;
                            out_data_next  = 8'h00;
                            out_len_next   = '0;
                            out_rtc_next   = 1'b0;
                            out_last_next  = 1'b1;
                        end
                    end else begin
                        item_ready = 1'b1;
                        meta_re    = 1'b1;
                        addr_next  = rbase_reg;
                        rslot_next = (rslot_reg == LAST_SLOT) ? '0 : rslot_reg + 1'b1;
                        rbase_next = (rbase_reg == LAST_BASE) ? '0 : rbase_reg + STRIDE;
                        state_next = S_META;
                    end
                end
            end
            S_META: begin
                if (meta_len == '0) begin
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        out_ev_next    = EV_EMPTY_LINE;
                        out_data_next  = 8'h00;
                        out_len_next   = '0;
                        out_rtc_next   = 1'b0;
                        out_last_next  = 1'b1;
                        state_next     = S_IDLE;
                    end
                end else begin
                    len_next   = meta_len;
                    rtc_next   = meta_rd_reg[FILL_W];
                    cnt_next   = '0;
                    byte_re    = 1'b1;
                    addr_next  = addr_reg + 1'b1;
                    state_next = S_STREAM;
                end
            end
            S_STREAM: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_ev_next    = EV_BYTE;
                    out_data_next  = byte_rd_reg;
                    out_len_next   = LEN_W'(len_reg);
                    out_rtc_next   = rtc_reg;
                    out_last_next  = (cnt_reg == len_reg - 1'b1);
                    if (cnt_reg == len_reg - 1'b1) begin
                        state_next = S_IDLE;
                    end else begin
                        byte_re   = 1'b1;
                        addr_next = addr_reg + 1'b1;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            wslot_reg     <= '0;
            rslot_reg     <= '0;
            wbase_reg     <= '0;
            rbase_reg     <= '0;
            fill_reg      <= '0;
            prefix_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wslot_reg     <= wslot_next;
            rslot_reg     <= rslot_next;
            wbase_reg     <= wbase_next;
            rbase_reg     <= rbase_next;
            fill_reg      <= fill_next;
            prefix_reg    <= prefix_next;
            out_valid_reg <= out_valid_next;
        end
        addr_reg     <= addr_next;
        cnt_reg      <= cnt_next;
        len_reg      <= len_next;
        rtc_reg      <= rtc_next;
        out_ev_reg   <= out_ev_next;
        out_data_reg <= out_data_next;
        out_len_reg  <= out_len_next;
        out_rtc_reg  <= out_rtc_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (byte_we) begin
            line_mem[byte_waddr] <= item.rx_byte;
        end
        if (byte_re) begin
            byte_rd_reg <= line_mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[wslot_reg] <= meta_wdata;
        end
        if (meta_re) begin
            meta_rd_reg <= meta_mem[rslot_reg];
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_event_res   = out_ev_reg;
    assign m_data_byte   = out_data_reg;
    assign m_line_length = out_len_reg;
    assign m_rtc_command = out_rtc_reg;
    assign m_last        = out_last_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= MAX_FILL)
        else $error("open line exceeds slot capacity");

    a_stream_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_STREAM |-> (len_reg != '0 && cnt_reg < len_reg))
        else $error("stream index out of line");

    a_no_write_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_we || meta_we) |-> !full)
        else $error("write into full ring");

    a_meta_follows_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        meta_re |=> state_reg == S_META)
        else $error("length lookup without read");

endmodule

@@ rtl/core/line_assembly_ring_queue_unit.sv @@
// A received byte's result passes the input queue and the result register. One received
// byte per cycle while the back end is idle and m_ready holds; a dequeue presents its first
// line byte after a length table read, a line store read and the result register, then one
// per cycle while m_ready holds. Dequeue of an empty ring or an empty line gives one result;
// the back end works one item at a time while a two-entry input queue keeps accepting beats.
// Reset (aresetn, synchronous): ring pointers and open line cleared; memories not cleared.
module line_assembly_ring_queue_unit #(
    parameter int QUEUE_SLOTS = 16,
    parameter int LINE_BYTES  = 40
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_opcode,
    input  logic [7:0]                s_rx_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_event_res,
    output logic [7:0]                m_data_byte,
    output logic [laq_pkg::LEN_W-1:0] m_line_length,
    output logic                      m_rtc_command,
    output logic                      m_last
);
    import laq_pkg::*;

    item_t item;
    logic  item_valid;
    logic  item_ready;

    laq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_rx_byte  (s_rx_byte),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready)
    );

    laq_back #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .LINE_BYTES  (LINE_BYTES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item          (item),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_res   (m_event_res),
        .m_data_byte   (m_data_byte),
        .m_line_length (m_line_length),
        .m_rtc_command (m_rtc_command),
        .m_last        (m_last)
    );

endmodule
